// ===== rtl/core/swid_pkg.sv =====
// shared types and codes for the stack with indexed delete
// used by swid_cell and stack_with_indexed_delete; depends on nothing
`default_nettype none
package swid_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd2;
    localparam logic [OP_W-1:0] OP_POP     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_CREATED = 3'd1;
    localparam logic [ST_W-1:0] ST_ALREADY     = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL        = 3'd5;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             push;
        logic             pull;
        logic [POS_W-1:0] pull_from;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/swid_cell.sv =====
// one storage cell of the stack chain; cell 0 is the top of the stack
// depends on swid_pkg
`default_nettype none
module swid_cell #(
    parameter int IDX = 0
) (
    input  wire                          aclk,
    input  wire  swid_pkg::cell_ctrl_t   ctrl,
    input  wire  [swid_pkg::DATA_W-1:0]  prev_data,
    input  wire  [swid_pkg::DATA_W-1:0]  next_data,
    output logic [swid_pkg::DATA_W-1:0]  data_q
);
    import swid_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              in_pull;

    assign in_pull = ctrl.pull && (POS_W'(IDX) >= ctrl.pull_from);

    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            data_next = prev_data;
        end else if (in_pull) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/stack_with_indexed_delete.sv =====
// top level of the bounded stack with indexed read and delete
// depends on swid_pkg and swid_cell
// The stack is a chain of DEPTH cells, cell 0 holding the top. A push shifts
// the whole chain down by one, a pop or a delete at a position shifts the
// cells from that position on up by one, so every operation completes in the
// cycle it is accepted and its result word appears in the output register on
// the next cycle. One word is accepted per cycle as long as the output side
// takes results; the input stalls only while a result waits. The stack must
// be created before use; destroy clears it. Read and delete positions count
// from 1 at the top.
`default_nettype none
module stack_with_indexed_delete #(
    parameter int DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // push_value[31:0], position[39:32]
    input  wire  [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[34:32],
                                   // entry_count[41:35], is_empty[42],
                                   // is_full[43], zero[47:44]
);
    import swid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              created_reg, created_next;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    logic              accept;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] push_value;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  pos_idx;
    logic              pos_ok;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] rdata;
    logic [POS_W-1:0]  rd_sel;
    logic [7:0]        cnt_ext;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_q [DEPTH];

    assign op         = s_tuser;
    assign push_value = s_tdata[31:0];
    assign position   = s_tdata[39:32];
    assign pos_idx    = position - POS_W'(1);
    assign pos_ok     = (position != '0) && ({1'b0, position} <= 9'(cnt_reg));

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        status         = ST_OK;
        rd_sel         = '0;
        cnt_next       = cnt_reg;
        created_next   = created_reg;
        ctrl.push      = 1'b0;
        ctrl.pull      = 1'b0;
        ctrl.pull_from = '0;
        if (op == OP_CREATE) begin
            if (created_reg) begin
                status = ST_ALREADY;
            end else begin
                created_next = 1'b1;
                cnt_next     = '0;
            end
        end else if (op > OP_DELETE) begin
            status = ST_OK;
        end else if (!created_reg) begin
            status = ST_NOT_CREATED;
        end else if (op == OP_DESTROY) begin
            created_next = 1'b0;
            cnt_next     = '0;
        end else if (op == OP_PUSH) begin
            if (cnt_reg >= CW'(DEPTH)) begin
                status = ST_FULL;
            end else begin
                ctrl.push = accept;
                cnt_next  = cnt_reg + CW'(1);
            end
        end else if (cnt_reg == '0) begin
            status = ST_EMPTY;
        end else if (op == OP_POP) begin
            ctrl.pull = accept;
            cnt_next  = cnt_reg - CW'(1);
        end else if (!pos_ok) begin
            status = ST_NOT_FOUND;
        end else begin
            rd_sel = pos_idx;
            if (op == OP_DELETE) begin
                ctrl.pull      = accept;
                ctrl.pull_from = pos_idx;
                cnt_next       = cnt_reg - CW'(1);
            end
        end
    end

    always_comb begin
        rdata = '0;
        if (status == ST_OK && (op == OP_POP || op == OP_READ) && created_reg) begin
            rdata = cell_q[rd_sel[IW-1:0]];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (gi == 0) begin : g_top
                assign prev_d = push_value;
            end else begin : g_mid
                assign prev_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_bot
                assign next_d = '0;
            end else begin : g_up
                assign next_d = cell_q[gi+1];
            end
            swid_cell #(
                .IDX (gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .data_q    (cell_q[gi])
            );
        end
    endgenerate

    assign cnt_ext = 8'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            created_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                created_reg <= created_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {4'b0000,
                             (cnt_next == CW'(DEPTH)),
                             (cnt_next == '0),
                             cnt_ext[CNT_W-1:0],
                             status,
                             rdata};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
